// File: rtl/core/wstd_pkg.sv
// Package for the weighted server task dispatcher.
// Field widths, reset values and operation codes. No dependencies.
package wstd_pkg;

	localparam int MAX_SERVERS_DEF = 16;

	localparam int OP_W     = 1;
	localparam int IDX_W    = 4;
	localparam int WEIGHT_W = 16;
	localparam int DUR_W    = 16;
	localparam int TIME_W   = 48;
	localparam int CLK_W    = 32;
	localparam int CNT_W    = 5;

	localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(16);

	typedef enum logic [OP_W-1:0] {
		OP_LOAD = 1'b0,
		OP_TASK = 1'b1
	} op_t;

endpackage

// File: rtl/core/wstd_select.sv
// Server selection tree: least key among active servers, lowest index on ties.
// Key is {busy, finish if busy, weight}. Depends on wstd_pkg.
module wstd_select #(
	parameter int MAX_SERVERS = wstd_pkg::MAX_SERVERS_DEF,
	parameter int IW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1
) (
	input  logic [wstd_pkg::WEIGHT_W-1:0] weights  [MAX_SERVERS],
	input  logic [wstd_pkg::TIME_W-1:0]   finishes [MAX_SERVERS],
	input  logic [MAX_SERVERS-1:0]        active,
	input  logic [wstd_pkg::TIME_W-1:0]   now,
	output logic [IW-1:0]                 sel_idx
);

	localparam int P     = 1 << IW;
	localparam int NODES = 2 * P - 1;
	localparam int KEY_W = 1 + wstd_pkg::TIME_W + wstd_pkg::WEIGHT_W;

	logic             leaf_v [P];
	logic [KEY_W-1:0] leaf_k [P];

	for (genvar g = 0; g < P; g++) begin : g_leaf
		if (g < MAX_SERVERS) begin : g_real
			logic busy;
			assign busy      = finishes[g] > now;
			assign leaf_v[g] = active[g];
			assign leaf_k[g] = {busy, (busy ? finishes[g] : '0), weights[g]};
		end else begin : g_pad
			assign leaf_v[g] = 1'b0;
			assign leaf_k[g] = '0;
		end
	end

	logic             node_v [NODES];
	logic [KEY_W-1:0] node_k [NODES];
	logic [IW-1:0]    node_i [NODES];

	always_comb begin
		for (int i = 0; i < P; i++) begin
			node_v[P-1+i] = leaf_v[i];
			node_k[P-1+i] = leaf_k[i];
			node_i[P-1+i] = IW'(i);
		end
		for (int k = P - 2; k >= 0; k--) begin
			if (node_v[2*k+2] && (!node_v[2*k+1] || node_k[2*k+2] < node_k[2*k+1])) begin
				node_v[k] = node_v[2*k+2];
				node_k[k] = node_k[2*k+2];
				node_i[k] = node_i[2*k+2];
			end else begin
				node_v[k] = node_v[2*k+1];
				node_k[k] = node_k[2*k+1];
				node_i[k] = node_i[2*k+1];
			end
		end
	end

	assign sel_idx = node_i[0];

endmodule

// File: rtl/core/weighted_server_task_dispatcher.sv
// Weighted server task dispatcher: top level with input register, server state and result register.
// Depends on wstd_pkg and wstd_select.
// Throughput: one beat per cycle; a task beat waits while an unaccepted result is held.
// A task beat passes through the input register and then the result register.
// The selection tree and finish-time update are combinational, so each task sees the last one's state.
// Reset: weights, finish times and task clock clear to zero; server_count returns to 16.
module weighted_server_task_dispatcher #(
	parameter int MAX_SERVERS = wstd_pkg::MAX_SERVERS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [wstd_pkg::CNT_W-1:0]    cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [wstd_pkg::OP_W-1:0]     operation,
	input  logic [wstd_pkg::IDX_W-1:0]    server_index,
	input  logic [wstd_pkg::WEIGHT_W-1:0] weight,
	input  logic [wstd_pkg::DUR_W-1:0]    duration,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [wstd_pkg::IDX_W-1:0]    chosen_server,
	output logic [wstd_pkg::TIME_W-1:0]   start_time,
	output logic [wstd_pkg::TIME_W-1:0]   finish_time,
	output logic                          no_server
);

	localparam int IW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
	localparam int TW = wstd_pkg::TIME_W;

	logic                          valid_s1;
	wstd_pkg::op_t                 op_s1;
	logic [wstd_pkg::IDX_W-1:0]    idx_s1;
	logic [wstd_pkg::WEIGHT_W-1:0] weight_s1;
	logic [wstd_pkg::DUR_W-1:0]    dur_s1;

	logic [wstd_pkg::CNT_W-1:0]    server_count_q;
	logic [wstd_pkg::WEIGHT_W-1:0] weight_q [MAX_SERVERS];
	logic [TW-1:0]                 finish_q [MAX_SERVERS];
	logic [wstd_pkg::CLK_W-1:0]    task_clock_q;

	logic                          out_valid_q;
	logic [wstd_pkg::IDX_W-1:0]    chosen_server_q;
	logic [TW-1:0]                 start_time_q;
	logic [TW-1:0]                 finish_time_q;
	logic                          no_server_q;

	logic                          go_s1;
	logic                          task_go;
	logic                          load_go;
	logic                          none_active;
	logic [MAX_SERVERS-1:0]        active;
	logic [TW-1:0]                 now;
	logic [IW-1:0]                 sel_idx;
	logic [TW-1:0]                 sel_fin;
	logic [TW-1:0]                 start_c;
	logic [TW:0]                   sum_c;
	logic [TW-1:0]                 fin_c;

	assign go_s1       = valid_s1 && (op_s1 == wstd_pkg::OP_LOAD || !out_valid_q || !out_stall);
	assign task_go     = go_s1 && op_s1 == wstd_pkg::OP_TASK;
	assign load_go     = go_s1 && op_s1 == wstd_pkg::OP_LOAD;
	assign in_stall    = valid_s1 && !go_s1;
	assign none_active = server_count_q == '0;
	assign now         = TW'(task_clock_q);

	for (genvar g = 0; g < MAX_SERVERS; g++) begin : g_active
		assign active[g] = 32'(server_count_q) > g;
	end

	wstd_select #(
		.MAX_SERVERS(MAX_SERVERS),
		.IW(IW)
	) u_select (
		.weights(weight_q),
		.finishes(finish_q),
		.active(active),
		.now(now),
		.sel_idx(sel_idx)
	);

	always_comb begin
		sel_fin = '0;
		for (int i = 0; i < MAX_SERVERS; i++) begin
			if (sel_idx == IW'(i)) begin
				sel_fin = finish_q[i];
			end
		end
		start_c = (sel_fin > now) ? sel_fin : now;
		sum_c   = {1'b0, start_c} + (TW + 1)'(dur_s1);
		fin_c   = sum_c[TW] ? '1 : sum_c[TW-1:0];
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1     <= wstd_pkg::op_t'(operation);
			idx_s1    <= server_index;
			weight_s1 <= weight;
			dur_s1    <= duration;
		end
	end

	// server state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			server_count_q <= wstd_pkg::COUNT_RESET;
			task_clock_q   <= '0;
			for (int i = 0; i < MAX_SERVERS; i++) begin
				weight_q[i] <= '0;
				finish_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				server_count_q <= cfg_wdata;
			end
			if (task_go) begin
				task_clock_q <= task_clock_q + 1'b1;
			end
			for (int i = 0; i < MAX_SERVERS; i++) begin
				if (load_go && 32'(idx_s1) == i) begin
					weight_q[i] <= weight_s1;
				end
				if (task_go && !none_active && sel_idx == IW'(i)) begin
					finish_q[i] <= fin_c;
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (task_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (task_go) begin
			chosen_server_q <= none_active ? '0 : wstd_pkg::IDX_W'(sel_idx);
			start_time_q    <= none_active ? '0 : start_c;
			finish_time_q   <= none_active ? '0 : fin_c;
			no_server_q     <= none_active;
		end
	end

	assign out_valid     = out_valid_q;
	assign chosen_server = chosen_server_q;
	assign start_time    = start_time_q;
	assign finish_time   = finish_time_q;
	assign no_server     = no_server_q;

	a_no_server_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && no_server_q |-> chosen_server_q == '0 && start_time_q == '0
			&& finish_time_q == '0)
		else $error("no_server result carries nonzero fields");

	a_finish_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !no_server_q |-> finish_time_q >= start_time_q)
		else $error("finish time before start time");

	a_clock_advance: assert property (@(posedge clk) disable iff (!arst_n)
		task_go |=> task_clock_q == $past(task_clock_q) + 1'b1)
		else $error("task clock did not advance on a task");

	a_sel_active: assert property (@(posedge clk) disable iff (!arst_n)
		task_go && !none_active |-> 32'(sel_idx) < 32'(server_count_q)
			&& 32'(sel_idx) < MAX_SERVERS)
		else $error("selected server not in use");

	a_result_kept: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall && !task_go |=> out_valid_q && $stable(finish_time_q))
		else $error("stalled result lost");

endmodule

// File: tb/tb_weighted_server_task_dispatcher.sv
// Self-checking bench for weighted_server_task_dispatcher: directed and random beats,
// predicted dispatches compared field by field against the result channel.
// Depends on wstd_pkg and the dispatcher RTL.
module tb_weighted_server_task_dispatcher;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NSRV = wstd_pkg::MAX_SERVERS_DEF;
	localparam logic [wstd_pkg::TIME_W-1:0] TIME_MAX = '1;

	typedef struct {
		wstd_pkg::op_t                  op;
		logic [wstd_pkg::IDX_W-1:0]     idx;
		logic [wstd_pkg::WEIGHT_W-1:0]  wgt;
		logic [wstd_pkg::DUR_W-1:0]     dur;
	} job_t;

	typedef struct {
		logic [wstd_pkg::IDX_W-1:0]  id;
		logic [wstd_pkg::TIME_W-1:0] start;
		logic [wstd_pkg::TIME_W-1:0] fin;
		logic                        none;
	} dispatch_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_we = 1'b0;
	logic [wstd_pkg::CNT_W-1:0]    cfg_wdata = '0;
	logic                          in_valid = 1'b0;
	logic                          in_stall;
	logic [wstd_pkg::OP_W-1:0]     operation = '0;
	logic [wstd_pkg::IDX_W-1:0]    server_index = '0;
	logic [wstd_pkg::WEIGHT_W-1:0] weight = '0;
	logic [wstd_pkg::DUR_W-1:0]    duration = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic [wstd_pkg::IDX_W-1:0]    chosen_server;
	logic [wstd_pkg::TIME_W-1:0]   start_time;
	logic [wstd_pkg::TIME_W-1:0]   finish_time;
	logic                          no_server;

	job_t      pending_jobs[$];
	dispatch_t expected_dispatches[$];
	bit        offer_live = 0;
	int        send_idle_pct = 0;
	int        recv_idle_pct = 0;
	bit        hold_req = 0;
	int        hold_left = 0;
	int        fail_count = 0;

	// predictor state
	logic [wstd_pkg::WEIGHT_W-1:0] srv_weight[NSRV];
	logic [wstd_pkg::TIME_W-1:0]   srv_finish[NSRV];
	logic [wstd_pkg::CLK_W-1:0]    tick_count;
	logic [wstd_pkg::CNT_W-1:0]    srv_count;

	weighted_server_task_dispatcher dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.server_index(server_index),
		.weight(weight),
		.duration(duration),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.chosen_server(chosen_server),
		.start_time(start_time),
		.finish_time(finish_time),
		.no_server(no_server)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic void predict_dispatch(job_t j);
		dispatch_t r;
		int unsigned n, i, best;
		bit found;
		logic [wstd_pkg::TIME_W-1:0] tnow, st;
		logic [wstd_pkg::TIME_W:0] sum;
		if (j.op == wstd_pkg::OP_LOAD) begin
			srv_weight[j.idx] = j.wgt;
			return;
		end
		tnow = wstd_pkg::TIME_W'(tick_count);
		tick_count = tick_count + 1'b1;
		n = (srv_count > NSRV) ? NSRV : srv_count;
		r.id = '0;
		r.start = '0;
		r.fin = '0;
		r.none = 1'b0;
		if (n == 0) begin
			r.none = 1'b1;
			expected_dispatches = {expected_dispatches, r};
			return;
		end
		best = 0;
		found = 0;
		for (i = 0; i < n; i++) begin
			if (srv_finish[i] <= tnow && (!found || srv_weight[i] < srv_weight[best])) begin
				best = i;
				found = 1;
			end
		end
		if (!found) begin
			best = 0;
			for (i = 1; i < n; i++) begin
				if (srv_finish[i] < srv_finish[best] || (srv_finish[i] == srv_finish[best] &&
						srv_weight[i] < srv_weight[best]))
					best = i;
			end
		end
		st = (srv_finish[best] > tnow) ? srv_finish[best] : tnow;
		sum = {1'b0, st} + (wstd_pkg::TIME_W+1)'(j.dur);
		r.id = wstd_pkg::IDX_W'(best);
		r.start = st;
		r.fin = sum[wstd_pkg::TIME_W] ? TIME_MAX : sum[wstd_pkg::TIME_W-1:0];
		srv_finish[best] = r.fin;
		expected_dispatches = {expected_dispatches, r};
	endfunction

	task automatic report_mismatch(string what, logic [wstd_pkg::TIME_W-1:0] got,
			logic [wstd_pkg::TIME_W-1:0] want);
		$display("%0t mismatch %s: got %0h, expected %0h", $time, what, got, want);
		fail_count++;
	endtask

	// driver: new beat offered only once the previous one was taken
	always @(negedge clk) begin
		if (arst_n && !offer_live) begin
			if (pending_jobs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				operation <= pending_jobs[0].op;
				server_index <= pending_jobs[0].idx;
				weight <= pending_jobs[0].wgt;
				duration <= pending_jobs[0].dur;
				offer_live = 1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver stall, with an optional long hold-off
	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = 300;
			hold_req = 0;
		end
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// monitor
	always @(posedge clk) begin
		dispatch_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_dispatches.size() == 0) begin
					report_mismatch("result with none pending", '0, '0);
				end else begin
					want = expected_dispatches.pop_front();
					if (chosen_server !== want.id)
						report_mismatch("chosen_server", wstd_pkg::TIME_W'(chosen_server),
							wstd_pkg::TIME_W'(want.id));
					if (start_time !== want.start)
						report_mismatch("start_time", start_time, want.start);
					if (finish_time !== want.fin)
						report_mismatch("finish_time", finish_time, want.fin);
					if (no_server !== want.none)
						report_mismatch("no_server", wstd_pkg::TIME_W'(no_server),
							wstd_pkg::TIME_W'(want.none));
				end
			end
			if (in_valid && !in_stall) begin
				predict_dispatch(pending_jobs.pop_front());
				offer_live = 0;
			end
		end
	end

	task automatic set_server_count(logic [wstd_pkg::CNT_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		srv_count = v;
	endtask

	task automatic queue_load(logic [wstd_pkg::IDX_W-1:0] idx,
			logic [wstd_pkg::WEIGHT_W-1:0] w);
		job_t j;
		j.op = wstd_pkg::OP_LOAD;
		j.idx = idx;
		j.wgt = w;
		j.dur = wstd_pkg::DUR_W'($urandom_range(65535));
		pending_jobs = {pending_jobs, j};
	endtask

	task automatic queue_task(logic [wstd_pkg::DUR_W-1:0] d);
		job_t j;
		j.op = wstd_pkg::OP_TASK;
		j.idx = wstd_pkg::IDX_W'($urandom_range(15));
		j.wgt = wstd_pkg::WEIGHT_W'($urandom_range(65535));
		j.dur = d;
		pending_jobs = {pending_jobs, j};
	endtask

	task automatic drain();
		while (pending_jobs.size() != 0 || offer_live || expected_dispatches.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	initial begin
		static int counts[12] = '{3, 16, 2, 31, 1, 5, 0, 4, 17, 2, 8, 3};
		int ph, k, pick;
		for (k = 0; k < NSRV; k++) begin
			srv_weight[k] = '0;
			srv_finish[k] = '0;
		end
		tick_count = '0;
		srv_count = wstd_pkg::COUNT_RESET;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: reset count, zero and max durations, weight ties, busy path,
		// no servers, count above the server array, load to an unused server
		queue_task(16'd0);
		queue_task(16'hFFFF);
		queue_load(4'd15, 16'hFFFF);
		queue_load(4'd0, 16'hFFFF);
		queue_load(4'd1, 16'd0);
		queue_task(16'd3);
		queue_task(16'd3);
		drain();
		set_server_count(5'd1);
		queue_load(4'd9, 16'd7);
		queue_task(16'd2);
		queue_task(16'd2);
		queue_task(16'd2);
		drain();
		set_server_count(5'd0);
		queue_task(16'd5);
		queue_load(4'd2, 16'd1);
		queue_task(16'hFFFF);
		drain();
		set_server_count(5'd31);
		queue_task(16'd4);
		queue_task(16'd4);
		queue_load(4'd2, 16'd0);
		queue_task(16'd1);
		drain();
		set_server_count(5'd2);
		queue_load(4'd0, 16'd5);
		queue_load(4'd1, 16'd5);
		queue_task(16'd10);
		queue_task(16'd9);
		queue_task(16'd1);
		drain();

		for (ph = 0; ph < 12; ph++) begin
			case (ph / 4)
				0: begin
					send_idle_pct = 12;
					recv_idle_pct = 85;
				end
				1: begin
					send_idle_pct = 85;
					recv_idle_pct = 12;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			set_server_count(wstd_pkg::CNT_W'(counts[ph]));
			for (k = 0; k < 130; k++) begin
				if ($urandom_range(3) == 0) begin
					queue_load(wstd_pkg::IDX_W'($urandom_range(15)), ($urandom_range(1) == 0) ?
						wstd_pkg::WEIGHT_W'($urandom_range(3)) :
						wstd_pkg::WEIGHT_W'($urandom_range(65535)));
				end else begin
					pick = $urandom_range(99);
					if (pick < 85)
						queue_task(wstd_pkg::DUR_W'($urandom_range(12)));
					else if (pick < 97)
						queue_task(wstd_pkg::DUR_W'($urandom_range(200)));
					else
						queue_task(wstd_pkg::DUR_W'($urandom_range(65535)));
				end
			end
			if (ph == 1 || ph == 9)
				hold_req = 1;
			drain();
		end

		repeat (8) @(negedge clk);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
